FILE: src/dq_pkg.sv
// Shared types and codes for the double-ended queue.
`timescale 1ns / 1ps

package dq_pkg;

    // Fixed widths of the transfer fields.
    localparam int FIELD_W = 32;
    localparam int MODE_W  = 3;
    localparam int STAT_W  = 2;

    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [STAT_W-1:0] t_status;

    // Operation codes carried by the mode field.
    localparam t_mode MODE_PUSH_FRONT = 3'd0;
    localparam t_mode MODE_PUSH_BACK  = 3'd1;
    localparam t_mode MODE_POP_FRONT  = 3'd2;
    localparam t_mode MODE_POP_BACK   = 3'd3;
    localparam t_mode MODE_NOP        = 3'd4;

    // Result status codes.
    localparam t_status STAT_DONE  = 2'd0;
    localparam t_status STAT_FULL  = 2'd1;
    localparam t_status STAT_EMPTY = 2'd2;

    // Strobes from the sequencer to the entry memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

FILE: src/dq_mem.sv
// Entry memory: one write port and two registered read ports.
`timescale 1ns / 1ps

module dq_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  dq_pkg::t_mem_ctl  i_ctl,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [AW-1:0]     i_rd_addr_front,
    input  logic [AW-1:0]     i_rd_addr_back,
    output logic [WIDTH-1:0]  o_rd_front,
    output logic [WIDTH-1:0]  o_rd_back
);
    import dq_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_front;
    logic [WIDTH-1:0] r_rd_back;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read ports; the data holds until the next read strobe.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_front <= mem[i_rd_addr_front];
            r_rd_back  <= mem[i_rd_addr_back];
        end
    end

    assign o_rd_front = r_rd_front;
    assign o_rd_back  = r_rd_back;

endmodule

FILE: src/dq_ctrl.sv
// Sequencer: head and count update, memory addressing and handshakes.
`timescale 1ns / 1ps

module dq_ctrl #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  dq_pkg::t_mode     i_mode,
    output logic              o_valid,
    input  logic              i_stall,
    output dq_pkg::t_mem_ctl  o_mem_ctl,
    output logic [AW-1:0]     o_wr_addr,
    output logic [AW-1:0]     o_rd_addr_front,
    output logic [AW-1:0]     o_rd_addr_back,
    output logic [CW-1:0]     o_count,
    output dq_pkg::t_status   o_status
);
    import dq_pkg::*;

    localparam int SUMW = CW + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    t_status       r_status, n_status;

    logic            accept;
    logic            full;
    logic            empty;
    logic [AW-1:0]   head_dec;
    logic [AW-1:0]   head_inc;
    logic [SUMW-1:0] tail_sum;
    logic [AW-1:0]   tail;
    logic [AW-1:0]   back;
    logic            wr_en;

    assign accept = i_valid && (r_state == S_IDLE);
    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);

    // Circular index arithmetic; the store need not be a power of two deep.
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign tail_sum = SUMW'(r_head) + SUMW'(r_count);
    assign tail     = (tail_sum >= SUMW'(DEPTH)) ? AW'(tail_sum - SUMW'(DEPTH))
                                                 : AW'(tail_sum);
    assign back     = (tail == '0) ? AW'(DEPTH - 1) : tail - AW'(1);

    // Operation decode, applied in the cycle the input transfer happens.
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = r_status;
        wr_en    = 1'b0;
        o_wr_addr = tail;
        if (accept) begin
            n_status = STAT_DONE;
            unique case (i_mode)
                MODE_PUSH_FRONT: begin
                    if (full) begin
                        n_status = STAT_FULL;
                    end else begin
                        n_head    = head_dec;
                        n_count   = r_count + CW'(1);
                        wr_en     = 1'b1;
                        o_wr_addr = head_dec;
                    end
                end
                MODE_PUSH_BACK: begin
                    if (full) begin
                        n_status = STAT_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                        wr_en   = 1'b1;
                    end
                end
                MODE_POP_FRONT: begin
                    if (empty) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        n_head  = head_inc;
                        n_count = r_count - CW'(1);
                    end
                end
                MODE_POP_BACK: begin
                    if (empty) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
                default: begin
                    n_status = STAT_DONE;
                end
            endcase
        end
    end

    // Sequence: take the operation, read both ends, present the result.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_READ;
            S_READ: n_state = S_OUT;
            S_OUT:  if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_status <= STAT_DONE;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    assign o_mem_ctl.wr_en = wr_en;
    assign o_mem_ctl.rd_en = (r_state == S_READ);
    assign o_rd_addr_front = r_head;
    assign o_rd_addr_back  = back;
    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_count         = r_count;
    assign o_status        = r_status;

endmodule

FILE: src/double_ended_queue.sv
// The sequencer takes an operation, reads both ends of the entry memory, then presents the result;
// it takes no new operation until that result has been taken, so a stalled result holds off the input.
// Reset (synchronous, active low) empties the queue: head and count go to zero.
// Entry memory contents are not cleared; only written entries are ever shown.
`timescale 1ns / 1ps

module double_ended_queue #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  dq_pkg::t_mode                 i_mode,
    input  logic [dq_pkg::FIELD_W-1:0]    i_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dq_pkg::FIELD_W-1:0]    o_front_value,
    output logic [dq_pkg::FIELD_W-1:0]    o_back_value,
    output logic                          o_is_empty,
    output logic [$clog2(DEPTH + 1)-1:0]  o_entry_count,
    output dq_pkg::t_status               o_status
);
    import dq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;

    t_mem_ctl      mem_ctl;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr_front;
    logic [AW-1:0] rd_addr_back;
    logic [SW-1:0] rd_front;
    logic [SW-1:0] rd_back;
    logic [CW-1:0] count;
    logic          empty;

    dq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_mem_ctl       (mem_ctl),
        .o_wr_addr       (wr_addr),
        .o_rd_addr_front (rd_addr_front),
        .o_rd_addr_back  (rd_addr_back),
        .o_count         (count),
        .o_status        (o_status)
    );

    // Words are stored at the data width; wider input bits are dropped.
    dq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (SW),
        .AW    (AW)
    ) u_mem (
        .i_clk           (i_clk),
        .i_ctl           (mem_ctl),
        .i_wr_addr       (wr_addr),
        .i_wr_data       (i_value[SW-1:0]),
        .i_rd_addr_front (rd_addr_front),
        .i_rd_addr_back  (rd_addr_back),
        .o_rd_front      (rd_front),
        .o_rd_back       (rd_back)
    );

    // An empty queue shows zero at both ends.
    assign empty         = (count == '0);
    assign o_is_empty    = empty;
    assign o_entry_count = count;
    assign o_front_value = empty ? '0 : FIELD_W'(rd_front);
    assign o_back_value  = empty ? '0 : FIELD_W'(rd_back);

endmodule

FILE: src/dq_chk.sv
// Port-level checks for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps

module dq_chk #(
    parameter int DEPTH = 1024
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [dq_pkg::FIELD_W-1:0]    o_front_value,
    input logic [dq_pkg::FIELD_W-1:0]    o_back_value,
    input logic                          o_is_empty,
    input logic [$clog2(DEPTH + 1)-1:0]  o_entry_count,
    input dq_pkg::t_status               o_status
);
    import dq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // A stalled result stays valid and holds its front, back, count and status.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_front_value)
            && $stable(o_back_value) && $stable(o_entry_count) && $stable(o_status))
        else $error("stalled result changed");

    // While a result is offered, the empty flag agrees with the count.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    // An empty queue shows zero at both ends.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> (o_front_value == '0) && (o_back_value == '0))
        else $error("empty queue shows nonzero data");

    // A dropped push leaves the queue full.
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_FULL) |-> (o_entry_count == CW'(DEPTH)))
        else $error("push dropped while not full");

    // An ignored pop leaves the queue empty.
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_EMPTY) |-> o_is_empty)
        else $error("pop ignored while not empty");

endmodule

bind double_ended_queue dq_chk #(
    .DEPTH (DEPTH)
) u_dq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_front_value (o_front_value),
    .o_back_value  (o_back_value),
    .o_is_empty    (o_is_empty),
    .o_entry_count (o_entry_count),
    .o_status      (o_status)
);

FILE: tb/double_ended_queue_tb.sv
// Self-checking testbench for the double-ended queue: directed, fill and random operations.
`timescale 1ns / 1ps

module double_ended_queue_tb;

    import dq_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int DATA_WIDTH  = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int COUNT_W     = $clog2(DEPTH + 1);
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_OPS  = 25;

    // Mode codes the block treats as no operation.
    localparam t_mode MODE_UNUSED_A = 3'd5;
    localparam t_mode MODE_UNUSED_B = 3'd6;
    localparam t_mode MODE_UNUSED_C = 3'd7;

    typedef struct packed {
        logic [FIELD_W-1:0] front;
        logic [FIELD_W-1:0] back;
        logic               empty;
        logic [COUNT_W-1:0] count;
        t_status            status;
    } t_deque_view;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    t_mode                i_mode;
    logic [FIELD_W-1:0]   i_value;
    logic                 o_valid;
    logic                 i_stall;
    logic [FIELD_W-1:0]   o_front_value;
    logic [FIELD_W-1:0]   o_back_value;
    logic                 o_is_empty;
    logic [COUNT_W-1:0]   o_entry_count;
    t_status              o_status;

    // Predicted queue contents.
    logic [FIELD_W-1:0]   deque_words [DEPTH];
    logic [IDX_W-1:0]     deque_head;
    logic [COUNT_W-1:0]   deque_count;

    t_deque_view          expected_views[$];
    int                   fail_count   = 0;
    int                   quiet_cycles = 0;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   holdoff_len    = 0;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_is_empty    (o_is_empty),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one operation to the predicted queue and return the view that follows it.
    function automatic t_deque_view predict_deque_op(input t_mode op,
                                                     input logic [FIELD_W-1:0] word);
        t_deque_view      view;
        logic [IDX_W-1:0] tail_idx;
        view.status = STAT_DONE;
        case (op)
            MODE_PUSH_FRONT: begin
                if (deque_count >= COUNT_W'(DEPTH)) begin
                    view.status = STAT_FULL;
                end else begin
                    deque_head = deque_head - 1'b1;
                    deque_words[deque_head] = word;
                    deque_count = deque_count + 1'b1;
                end
            end
            MODE_PUSH_BACK: begin
                if (deque_count >= COUNT_W'(DEPTH)) begin
                    view.status = STAT_FULL;
                end else begin
                    tail_idx = deque_head + deque_count[IDX_W-1:0];
                    deque_words[tail_idx] = word;
                    deque_count = deque_count + 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (deque_count == 0) begin
                    view.status = STAT_EMPTY;
                end else begin
                    deque_head = deque_head + 1'b1;
                    deque_count = deque_count - 1'b1;
                end
            end
            MODE_POP_BACK: begin
                if (deque_count == 0) begin
                    view.status = STAT_EMPTY;
                end else begin
                    deque_count = deque_count - 1'b1;
                end
            end
            default: begin
            end
        endcase
        view.count = deque_count;
        view.empty = (deque_count == 0);
        if (deque_count == 0) begin
            view.front = '0;
            view.back  = '0;
        end else begin
            tail_idx   = deque_head + deque_count[IDX_W-1:0] - 1'b1;
            view.front = deque_words[deque_head];
            view.back  = deque_words[tail_idx];
        end
        return view;
    endfunction

    // Offer one operation, wait for its transfer, then record the predicted view.
    task automatic issue_op(input t_mode op, input logic [FIELD_W-1:0] word);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_mode  <= op;
        i_value <= word;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_views.push_back(predict_deque_op(op, word));
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // An empty queue: no operation, pops on empty and the unused mode codes.
    task automatic test_empty_queue();
        issue_op(MODE_NOP, 32'hFFFF_FFFF);
        issue_op(MODE_POP_FRONT, 32'h1234_5678);
        issue_op(MODE_POP_BACK, 32'hFFFF_FFFF);
        issue_op(MODE_UNUSED_A, 32'h0000_0001);
        issue_op(MODE_UNUSED_B, 32'h8000_0000);
        issue_op(MODE_UNUSED_C, 32'hFFFF_FFFF);
    endtask

    // Pushes and pops at both ends with extreme data words.
    task automatic test_both_ends();
        issue_op(MODE_PUSH_FRONT, 32'h0000_0000);
        issue_op(MODE_PUSH_BACK, 32'hFFFF_FFFF);
        issue_op(MODE_PUSH_FRONT, 32'hAAAA_AAAA);
        issue_op(MODE_PUSH_BACK, 32'h5555_5555);
        issue_op(MODE_NOP, 32'h0);
        issue_op(MODE_UNUSED_C, 32'h0);
        issue_op(MODE_POP_FRONT, 32'h0);
        issue_op(MODE_POP_BACK, 32'h0);
        issue_op(MODE_POP_FRONT, 32'h0);
        issue_op(MODE_POP_BACK, 32'h0);
        issue_op(MODE_POP_BACK, 32'h0);
        issue_op(MODE_PUSH_BACK, 32'h8000_0001);
        issue_op(MODE_POP_FRONT, 32'h0);
    endtask

    // Fill the store to capacity, push into a full store, then work at the full boundary.
    task automatic test_fill_to_capacity();
        while (deque_count < COUNT_W'(DEPTH)) begin
            issue_op($urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, $urandom());
        end
        issue_op(MODE_PUSH_FRONT, $urandom());
        issue_op(MODE_PUSH_BACK, $urandom());
        issue_op(MODE_NOP, $urandom());
        issue_op(MODE_POP_BACK, $urandom());
        issue_op(MODE_PUSH_BACK, $urandom());
        issue_op(MODE_PUSH_FRONT, $urandom());
    endtask

    // The receiver holds off for a long stretch while operations keep coming.
    task automatic test_output_holdoff();
        holdoff_len = 400;
        for (int n = 0; n < 60; n++) begin
            issue_op(n % 3 == 2 ? MODE_POP_FRONT : MODE_PUSH_BACK, $urandom());
        end
    endtask

    // Random operations in segments that lean toward pushes, toward pops, or to neither.
    task automatic test_random_traffic(input int num_ops);
        int push_pct;
        int pick;
        t_mode op;
        push_pct = 50;
        for (int n = 0; n < num_ops; n++) begin
            if (n % 50 == 0) begin
                push_pct = 25 + 25 * $urandom_range(2);
            end
            pick = $urandom_range(99);
            if (pick < 6) begin
                op = t_mode'($urandom_range(7));
            end else if ($urandom_range(99) < push_pct) begin
                op = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
            end else begin
                op = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
            end
            issue_op(op, $urandom());
        end
    endtask

    // Compare one result transfer with the oldest predicted view.
    task automatic check_view();
        t_deque_view want;
        if (expected_views.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("unexpected result: front=%h back=%h empty=%0d count=%0d status=%0d",
                         o_front_value, o_back_value, o_is_empty, o_entry_count, o_status);
            end
        end else begin
            want = expected_views.pop_front();
            if (o_front_value !== want.front || o_back_value !== want.back ||
                o_is_empty !== want.empty || o_entry_count !== want.count ||
                o_status !== want.status) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("mismatch: expected front=%h back=%h empty=%0d count=%0d status=%0d",
                             want.front, want.back, want.empty, want.count, want.status);
                    $display("          actual   front=%h back=%h empty=%0d count=%0d status=%0d",
                             o_front_value, o_back_value, o_is_empty, o_entry_count,
                             o_status);
                end
            end
        end
    endtask

    // Result side: check every completed transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            check_view();
        end
    end

    // Receiver stall, with an optional long hold-off counted here.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_len > 0) begin
                i_stall <= 1'b1;
                holdoff_len--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[double_ended_queue] ERROR");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_mode  <= MODE_NOP;
        i_value <= '0;
        deque_head  = '0;
        deque_count = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(0, 0);
        test_empty_queue();
        set_idling(12, 12);
        test_both_ends();
        set_idling(0, 0);
        test_fill_to_capacity();
        test_output_holdoff();

        set_idling(0, 0);
        test_random_traffic(RANDOM_OPS);
        set_idling(80, 0);
        test_random_traffic(RANDOM_OPS);
        set_idling(0, 80);
        test_random_traffic(RANDOM_OPS);
        set_idling(12, 12);
        test_random_traffic(RANDOM_OPS);

        i_valid <= 1'b0;
        while (expected_views.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_views.size() == 0) begin
            $display("[double_ended_queue] OK");
        end else begin
            $display("[double_ended_queue] ERROR");
        end
        $finish;
    end

endmodule
